// File: src/brs_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the bilinear rgba scaler
package brs_pkg;

   localparam int MAX_SRC_WIDTH  = 256;
   localparam int MAX_SRC_HEIGHT = 256;
   localparam int STORE_DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int ADDR_W         = $clog2(STORE_DEPTH);
   localparam int COL_W          = $clog2(MAX_SRC_WIDTH);
   localparam int ROW_W          = $clog2(MAX_SRC_HEIGHT);

   localparam int PIXEL_W   = 32;
   localparam int COORD_W   = 12;
   localparam int SIZE_W    = 9;
   localparam int STEP_W    = 25;
   localparam int FRAC_W    = 16;
   localparam int POS_W     = COORD_W + STEP_W;
   localparam int INT_W     = POS_W - FRAC_W;
   localparam int WEIGHT_W  = FRAC_W + 1;
   localparam int CHAN_W    = 8;
   localparam int CHANNELS  = 4;
   localparam int HSUM_W    = CHAN_W + FRAC_W;
   localparam int VSUM_W    = HSUM_W + WEIGHT_W;

   localparam int REQ_DATA_W = 2 * COORD_W + PIXEL_W;
   localparam int RSP_DATA_W = PIXEL_W + 2 * COORD_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = STEP_W;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZONTAL_STEP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTICAL_STEP   = 3'd3;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_COMPUTE = 1'b1;

   localparam logic [SIZE_W-1:0] MAX_W_SIZE = SIZE_W'(MAX_SRC_WIDTH);
   localparam logic [SIZE_W-1:0] MAX_H_SIZE = SIZE_W'(MAX_SRC_HEIGHT);
   localparam logic [STEP_W-1:0] UNIT_STEP  = STEP_W'(1 << FRAC_W);
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << FRAC_W);

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [HSUM_W-1:0]  hsum_type;

endpackage

// File: src/brs_ram.sv
`timescale 1ns / 1ps
// generic single-port ram with registered read
module brs_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [DATA_W-1:0]        wdata,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/bilinear_rgba_scaler_core.sv
`timescale 1ns / 1ps
// bilinear rgba scaler top level: frame store, address mapping, interpolation
// a load beat writes the frame store in its accept cycle; loads run one per cycle while the core is idle
// a compute beat runs from accept to result register through multiply, clamp,
// four single-port frame store reads, drain, horizontal then vertical interpolation, output
// input is ready again the cycle after the result register loads; no new request is taken before then
// reset (synchronous, active high) restores size and step registers; frame store undefined until loaded
module bilinear_rgba_scaler_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [brs_pkg::REQ_DATA_W-1:0]  req_tdata,   // coord_x, coord_y, pixel_in
   input  logic                            req_tuser,   // command
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [brs_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // pixel_out, out_x, out_y
   input  logic                            csr_we,
   input  logic [brs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [brs_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_CLAMP = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_HORZ  = 3'd5;
   localparam logic [2:0] S_VERT  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;

   logic [brs_pkg::SIZE_W-1:0] width_ff, height_ff;
   logic [brs_pkg::STEP_W-1:0] hstep_ff, vstep_ff;

   logic [brs_pkg::COORD_W-1:0] cx_ff, cy_ff, cx_in, cy_in;
   logic [brs_pkg::POS_W-1:0]   px_ff, py_ff, px_in, py_in;
   logic [brs_pkg::COL_W-1:0]   x1_ff, x2_ff, x1_in, x2_in;
   logic [brs_pkg::ROW_W-1:0]   y1_ff, y2_ff, y1_in, y2_in;
   logic [brs_pkg::FRAC_W-1:0]  fx_ff, fy_ff;
   logic [1:0]                  rd_cnt_ff, rd_cnt_in;
   logic                        cap_ff;
   brs_pkg::pixel_type          pix_ff [brs_pkg::CHANNELS];
   brs_pkg::hsum_type           top_ff [brs_pkg::CHANNELS];
   brs_pkg::hsum_type           bot_ff [brs_pkg::CHANNELS];
   brs_pkg::hsum_type           top_in [brs_pkg::CHANNELS];
   brs_pkg::hsum_type           bot_in [brs_pkg::CHANNELS];
   brs_pkg::pixel_type          res_ff, res_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [brs_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [brs_pkg::SIZE_W-1:0]  w_eff, h_eff;
   logic                        req_fire, load_hit;
   logic [brs_pkg::COORD_W-1:0] req_x, req_y;
   brs_pkg::pixel_type          req_pixel;
   logic [brs_pkg::INT_W-1:0]   ix, iy;
   logic [brs_pkg::SIZE_W-1:0]  x1_next, y1_next;
   logic [brs_pkg::COL_W-1:0]   rd_col;
   logic [brs_pkg::ROW_W-1:0]   rd_row;
   logic [brs_pkg::ADDR_W-1:0]  ram_addr;
   logic                        ram_we;
   brs_pkg::pixel_type          ram_q;
   logic [brs_pkg::WEIGHT_W-1:0] wx0, wx1, wy0, wy1;
   logic [brs_pkg::VSUM_W-1:0]  vsum;
   logic                        out_load;

   // size registers with zero and oversize folded
   always_comb begin
      priority if (width_ff == '0) begin
         w_eff = brs_pkg::SIZE_W'(1);
      end else if (width_ff > brs_pkg::MAX_W_SIZE) begin
         w_eff = brs_pkg::MAX_W_SIZE;
      end else begin
         w_eff = width_ff;
      end
      priority if (height_ff == '0) begin
         h_eff = brs_pkg::SIZE_W'(1);
      end else if (height_ff > brs_pkg::MAX_H_SIZE) begin
         h_eff = brs_pkg::MAX_H_SIZE;
      end else begin
         h_eff = height_ff;
      end
   end

   assign req_x     = req_tdata[brs_pkg::COORD_W-1:0];
   assign req_y     = req_tdata[2*brs_pkg::COORD_W-1:brs_pkg::COORD_W];
   assign req_pixel = req_tdata[brs_pkg::REQ_DATA_W-1:2*brs_pkg::COORD_W];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign load_hit   = req_fire && (req_tuser == brs_pkg::CMD_LOAD)
                       && (req_x < brs_pkg::COORD_W'(w_eff))
                       && (req_y < brs_pkg::COORD_W'(h_eff));

   // frame store port: load writes in idle, reads during the fetch sweep
   assign rd_col = rd_cnt_ff[0] ? x2_ff : x1_ff;
   assign rd_row = rd_cnt_ff[1] ? y2_ff : y1_ff;
   assign ram_we = load_hit;
   always_comb begin
      if (state_ff == S_READ) begin
         ram_addr = brs_pkg::ADDR_W'(rd_row) * brs_pkg::ADDR_W'(brs_pkg::MAX_SRC_WIDTH)
                    + brs_pkg::ADDR_W'(rd_col);
      end else begin
         ram_addr = brs_pkg::ADDR_W'(req_y[brs_pkg::ROW_W-1:0])
                    * brs_pkg::ADDR_W'(brs_pkg::MAX_SRC_WIDTH)
                    + brs_pkg::ADDR_W'(req_x[brs_pkg::COL_W-1:0]);
      end
   end

   brs_ram #(
      .DATA_W (brs_pkg::PIXEL_W),
      .DEPTH  (brs_pkg::STORE_DEPTH)
   ) u_frame_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_pixel),
      .rdata (ram_q)
   );

   // source position
   assign cx_in = req_fire ? req_x : cx_ff;
   assign cy_in = req_fire ? req_y : cy_ff;
   assign px_in = brs_pkg::POS_W'(cx_ff) * brs_pkg::POS_W'(hstep_ff);
   assign py_in = brs_pkg::POS_W'(cy_ff) * brs_pkg::POS_W'(vstep_ff);

   // neighbor clamp at the far edge
   assign ix = px_ff[brs_pkg::POS_W-1:brs_pkg::FRAC_W];
   assign iy = py_ff[brs_pkg::POS_W-1:brs_pkg::FRAC_W];
   always_comb begin
      if (ix >= brs_pkg::INT_W'(w_eff)) begin
         x1_in = brs_pkg::COL_W'(w_eff - brs_pkg::SIZE_W'(1));
      end else begin
         x1_in = ix[brs_pkg::COL_W-1:0];
      end
      if (iy >= brs_pkg::INT_W'(h_eff)) begin
         y1_in = brs_pkg::ROW_W'(h_eff - brs_pkg::SIZE_W'(1));
      end else begin
         y1_in = iy[brs_pkg::ROW_W-1:0];
      end
      x1_next = brs_pkg::SIZE_W'(x1_in) + brs_pkg::SIZE_W'(1);
      y1_next = brs_pkg::SIZE_W'(y1_in) + brs_pkg::SIZE_W'(1);
      x2_in = (x1_next < w_eff) ? brs_pkg::COL_W'(x1_next)
                                : brs_pkg::COL_W'(w_eff - brs_pkg::SIZE_W'(1));
      y2_in = (y1_next < h_eff) ? brs_pkg::ROW_W'(y1_next)
                                : brs_pkg::ROW_W'(h_eff - brs_pkg::SIZE_W'(1));
   end

   // horizontal then vertical weighting per channel
   assign wx1 = brs_pkg::WEIGHT_W'(fx_ff);
   assign wx0 = brs_pkg::WEIGHT_ONE - wx1;
   assign wy1 = brs_pkg::WEIGHT_W'(fy_ff);
   assign wy0 = brs_pkg::WEIGHT_ONE - wy1;

   always_comb begin
      for (int c = 0; c < brs_pkg::CHANNELS; c++) begin
         top_in[c] = brs_pkg::HSUM_W'(
            brs_pkg::HSUM_W'(pix_ff[0][c*brs_pkg::CHAN_W +: brs_pkg::CHAN_W]) * brs_pkg::HSUM_W'(wx0)
          + brs_pkg::HSUM_W'(pix_ff[1][c*brs_pkg::CHAN_W +: brs_pkg::CHAN_W]) * brs_pkg::HSUM_W'(wx1));
         bot_in[c] = brs_pkg::HSUM_W'(
            brs_pkg::HSUM_W'(pix_ff[2][c*brs_pkg::CHAN_W +: brs_pkg::CHAN_W]) * brs_pkg::HSUM_W'(wx0)
          + brs_pkg::HSUM_W'(pix_ff[3][c*brs_pkg::CHAN_W +: brs_pkg::CHAN_W]) * brs_pkg::HSUM_W'(wx1));
      end
   end

   always_comb begin
      res_in = '0;
      vsum   = '0;
      for (int c = 0; c < brs_pkg::CHANNELS; c++) begin
         vsum = brs_pkg::VSUM_W'(top_ff[c]) * brs_pkg::VSUM_W'(wy0)
              + brs_pkg::VSUM_W'(bot_ff[c]) * brs_pkg::VSUM_W'(wy1);
         res_in[c*brs_pkg::CHAN_W +: brs_pkg::CHAN_W] =
            vsum[brs_pkg::VSUM_W-2 -: brs_pkg::CHAN_W];
      end
   end

   // sequencer
   assign out_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);
   always_comb begin
      state_in  = state_ff;
      rd_cnt_in = rd_cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_tuser == brs_pkg::CMD_COMPUTE)) begin
               state_in = S_MUL;
            end
         end
         S_MUL:   state_in = S_CLAMP;
         S_CLAMP: begin
            state_in  = S_READ;
            rd_cnt_in = '0;
         end
         S_READ: begin
            rd_cnt_in = rd_cnt_ff + 2'd1;
            if (rd_cnt_ff == 2'd3) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: state_in = S_HORZ;
         S_HORZ:  state_in = S_VERT;
         S_VERT:  state_in = S_DONE;
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {cy_ff, cx_ff, res_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= 1'b0;
         rd_cnt_ff    <= '0;
         width_ff     <= brs_pkg::MAX_W_SIZE;
         height_ff    <= brs_pkg::MAX_H_SIZE;
         hstep_ff     <= brs_pkg::UNIT_STEP;
         vstep_ff     <= brs_pkg::UNIT_STEP;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= (state_ff == S_READ);
         rd_cnt_ff    <= rd_cnt_in;
         if (csr_we) begin
            unique case (csr_index)
               brs_pkg::CSR_SOURCE_WIDTH:    width_ff  <= csr_data[brs_pkg::SIZE_W-1:0];
               brs_pkg::CSR_SOURCE_HEIGHT:   height_ff <= csr_data[brs_pkg::SIZE_W-1:0];
               brs_pkg::CSR_HORIZONTAL_STEP: hstep_ff  <= csr_data;
               brs_pkg::CSR_VERTICAL_STEP:   vstep_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      rsp_data_ff <= rsp_data_in;
      if (state_ff == S_MUL) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
      if (state_ff == S_CLAMP) begin
         x1_ff <= x1_in;
         x2_ff <= x2_in;
         y1_ff <= y1_in;
         y2_ff <= y2_in;
         fx_ff <= px_ff[brs_pkg::FRAC_W-1:0];
         fy_ff <= py_ff[brs_pkg::FRAC_W-1:0];
      end
      // read data shifts in, so the first fetch ends in the lowest slot
      if (cap_ff) begin
         for (int i = 0; i < brs_pkg::CHANNELS - 1; i++) begin
            pix_ff[i] <= pix_ff[i+1];
         end
         pix_ff[brs_pkg::CHANNELS-1] <= ram_q;
      end
      if (state_ff == S_HORZ) begin
         for (int c = 0; c < brs_pkg::CHANNELS; c++) begin
            top_ff[c] <= top_in[c];
            bot_ff[c] <= bot_in[c];
         end
      end
      if (state_ff == S_VERT) begin
         res_ff <= res_in;
      end
   end

endmodule
